// ----- rtl/sdasc_pkg.sv -----
// Package: widths, character codes, controller states and control/status bundles.
package sdasc_pkg;

  // Width of the signed input value
  localparam int VALUE_BITS = 32;

  // Conversion runs four magnitude bits per cycle
  localparam int STEPS  = (VALUE_BITS + 3) / 4;
  localparam int PAD_W  = STEPS * 4;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  // Decimal digits needed for the magnitude: floor(bits * log10(2)) + 1
  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_MINUS = 8'd45;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_FIND  = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DIGIT = 5'b10000
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;      // capture value, form magnitude, clear BCD
    logic step;      // one four-bit shift-add-3 step
    logic find;      // locate the leading nonzero digit
    logic dec;       // move to the next lower digit
    logic sel_sign;  // present '-' on the output
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic neg;       // captured value was negative
    logic idx_zero;  // digit pointer at least significant digit
  } sts_t;

endpackage

// ----- rtl/sdasc_in_if.sv -----
// Stream interfaces: signed value in, ASCII character out.
interface sdasc_in_if import sdasc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sdasc_out_if import sdasc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ----- rtl/sdasc_datapath.sv -----
// Datapath: magnitude shift register, BCD double-dabble register, digit pointer.
module sdasc_datapath import sdasc_pkg::*; (
  input  logic                         clk,
  input  cmd_t                         cmd,
  input  logic signed [VALUE_BITS-1:0] value,
  output sts_t                         sts,
  output logic [7:0]                   char_code,
  output logic                         last_char
);

  logic [PAD_W-1:0] mag_r;
  bcd_t             bcd_r;
  logic [IDX_W-1:0] idx_r;
  logic             neg_r;

  logic             neg_in;
  logic [VALUE_BITS-1:0] mag_in;
  logic [IDX_W-1:0] lead;

  // Four shift-add-3 iterations, most significant bit first
  function automatic bcd_t dabble4(input bcd_t bcd, input logic [3:0] bits);
    bcd_t             acc;
    logic [BCD_W-1:0] flat;
    acc = bcd;
    for (int b = 3; b >= 0; b--) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (acc[d] >= 4'd5) acc[d] = acc[d] + 4'd3;
      end
      flat = acc;
      acc  = {flat[BCD_W-2:0], bits[b]};
    end
    return acc;
  endfunction

  // Magnitude; the most negative value wraps to its exact unsigned magnitude
  assign neg_in = value[VALUE_BITS-1];
  assign mag_in = neg_in ? VALUE_BITS'(-value) : VALUE_BITS'(value);

  // Highest nonzero digit, zero when all digits are zero
  always_comb begin
    lead = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[d] != 4'd0) lead = IDX_W'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= PAD_W'(mag_in);
      neg_r <= neg_in;
      bcd_r <= '0;
    end else if (cmd.step) begin
      mag_r <= mag_r << 4;
      bcd_r <= dabble4(bcd_r, mag_r[PAD_W-1 -: 4]);
    end
    if (cmd.find) begin
      idx_r <= lead;
    end else if (cmd.dec) begin
      idx_r <= idx_r - IDX_W'(1);
    end
  end

  // Output character
  assign char_code = cmd.sel_sign ? CH_MINUS : (CH_ZERO + {4'b0000, bcd_r[idx_r]});
  assign last_char = !cmd.sel_sign && (idx_r == '0);

  assign sts.neg      = neg_r;
  assign sts.idx_zero = (idx_r == '0);

endmodule

// ----- rtl/sdasc_ctrl.sv -----
// Controller: sequences load, conversion steps, leading-digit search and emission.
module sdasc_ctrl import sdasc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(STEPS - 1)) state_nxt = ST_FIND;
      end
      ST_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = sts.neg ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        out_valid    = 1'b1;
        cmd.sel_sign = 1'b1;
        if (out_ready) state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.idx_zero) state_nxt = ST_IDLE;
          else              cmd.dec   = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  // One item at a time: never take input while characters are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("input taken while output pending");

  // An accepted beat always starts the conversion
  a_load_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CONV && cnt_r == '0))
    else $error("accept did not start conversion");

  // Conversion moves to the leading-digit search after its final step
  a_conv_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && cnt_r == STEP_W'(STEPS - 1)) |=> state_r == ST_FIND)
    else $error("conversion length wrong");

  // The final digit beat returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGIT && out_ready && sts.idx_zero) |=> state_r == ST_IDLE)
    else $error("last character did not end the item");
`endif

endmodule

// ----- rtl/signed_int_to_decimal_ascii_core.sv -----
// Top level: signed integer to decimal ASCII text converter.
//
// in_stream carries one signed VALUE_BITS-bit value per beat (valid/ready).
// out_stream returns its decimal text, one ASCII character per beat, most
// significant first: '-' for a negative value, then the digits without
// leading zeros; zero gives a single '0'. last_char marks the final beat.
// The most negative value converts exactly.
// Each item passes through an accept, the conversion steps (the shift-add-3
// register takes four magnitude bits per cycle), a search for the leading
// digit, then one beat per character, for 1 to 11 characters at 32 bits. The
// next value is accepted once the last character beat has been taken.
// A stalled receiver holds the current character and its flag steady; the
// converter waits with it. Synchronous active-low reset returns the block
// to idle and ready for input; no character is in flight after reset.
module signed_int_to_decimal_ascii_core import sdasc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  sdasc_in_if.sink      in_stream,
  sdasc_out_if.source   out_stream
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  sdasc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_stream.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sdasc_datapath u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .value     (in_stream.value),
    .sts       (sts),
    .char_code (out_stream.char_code),
    .last_char (out_stream.last_char)
  );

  assign in_stream.ready  = in_ready;
  assign out_stream.valid = out_valid;

endmodule
